@@ design/flvd_pkg.sv @@
// ----------------------------------------------------------------------------
// flvd_pkg
// Types and constants shared by the FLV tag demuxer modules.
// ----------------------------------------------------------------------------
package flvd_pkg;

   // Parser phase
   typedef enum logic [2:0] {
      PH_FILE  = 3'd0,
      PH_PREV  = 3'd1,
      PH_TAG   = 3'd2,
      PH_CODEC = 3'd3,
      PH_BODY  = 3'd4
   } phase_type;

   // Result event codes
   localparam logic [2:0] EV_FILE    = 3'd0;
   localparam logic [2:0] EV_PREV    = 3'd1;
   localparam logic [2:0] EV_TAG     = 3'd2;
   localparam logic [2:0] EV_AUDIO   = 3'd3;
   localparam logic [2:0] EV_VIDEO   = 3'd4;
   localparam logic [2:0] EV_PAYLOAD = 3'd5;
   localparam logic [2:0] EV_TRUNC   = 3'd6;

   localparam logic [7:0] TAG_AUDIO = 8'h08;
   localparam logic [7:0] TAG_VIDEO = 8'h09;
   localparam logic [3:0] FMT_AAC   = 4'd10;
   localparam logic [3:0] CODEC_AVC = 4'h7;

   localparam int CNT_W = 24;
   localparam logic [CNT_W-1:0] FILE_HDR_LEN = 24'd9;
   localparam logic [CNT_W-1:0] PREV_LEN     = 24'd4;
   localparam logic [CNT_W-1:0] TAG_HDR_LEN  = 24'd11;

   // Codec header lengths
   localparam logic [2:0] NEED_ONE  = 3'd1;
   localparam logic [2:0] NEED_AAC  = 3'd2;
   localparam logic [2:0] NEED_AVC  = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  byte_value;
      logic [7:0]  flags_byte;
      logic [3:0]  codec_format;
      logic [3:0]  rate_or_frame;
      logic        sample_bits;
      logic        stereo;
      logic [31:0] word_value;
      logic [23:0] data_size;
      logic [23:0] stream_ident;
      logic [23:0] composition_time;
      logic [7:0]  tag_kind;
   } rsp_type;

   // One parse step's outcome
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } step_res_type;

endpackage

@@ design/flv_container_demuxer.sv @@
// ----------------------------------------------------------------------------
// flv_container_demuxer
// Streaming FLV demuxer: file header, previous tag sizes, tag headers,
// audio/video codec headers and payload bytes, one input byte per transfer.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  req_data  (byte, last flag)
//   rsp_     out        rsp_valid/rsp_ready  rsp_data  (event and fields)
//
// One byte per clock sustained while results are taken; each byte waits in the
// input register and its result (if any) is loaded into the result register
// when the parser steps on it. The parser state machine is the only loop.
// Synchronous reset returns the parser to the file header phase.
// A stalled result holds the result register; one more byte still enters
// the input register, then req_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module flv_container_demuxer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  flvd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output flvd_pkg::rsp_type rsp_data
);
   import flvd_pkg::*;

   logic         item_valid;
   req_type      item;
   logic         out_free;
   logic         step;
   step_res_type res;

   // advance a byte whenever the result register can take its outcome
   assign step = item_valid && out_free;

   flvd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .take       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   flvd_parser u_parser (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (item),
      .res   (res)
   );

   flvd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .res       (res),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/flvd_in_reg.sv @@
// ----------------------------------------------------------------------------
// flvd_in_reg
// Input register: holds one byte until the parser takes it.
// ----------------------------------------------------------------------------
module flvd_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  flvd_pkg::req_type req_data,
   input  logic             take,
   output logic             item_valid,
   output flvd_pkg::req_type item
);
   import flvd_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff;

   assign req_ready  = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

endmodule

@@ design/flvd_parser.sv @@
// ----------------------------------------------------------------------------
// flvd_parser
// FLV header/tag state machine: consumes one byte per step and produces at
// most one result for it.
// ----------------------------------------------------------------------------
module flvd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  flvd_pkg::req_type      item,
   output flvd_pkg::step_res_type res
);
   import flvd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [23:0] cnt_ff, cnt_in;
   logic [31:0] gather_ff, gather_in;
   logic [7:0]  type_ff, type_in;
   logic [23:0] size_ff, size_in;
   logic [31:0] ts_ff, ts_in;
   logic [23:0] stream_ff, stream_in;
   logic [31:0] codec_ff, codec_in;

   logic [7:0]  b;
   logic [23:0] cnt_inc;
   logic [31:0] codec_upd;
   logic [7:0]  b0;
   logic        audio;
   logic [2:0]  need;
   logic        file_end, prev_end, tag_end, body_end, codec_end;
   logic        done, has_res;

   assign b         = item.data_byte;
   assign cnt_inc   = cnt_ff + 24'd1;
   assign codec_upd = codec_ff | ({24'd0, b} << {cnt_ff[1:0], 3'b000});
   assign b0        = codec_upd[7:0];
   assign audio     = (type_ff == TAG_AUDIO);

   always_comb begin
      if (audio) begin
         need = (b0[7:4] == FMT_AAC) ? NEED_AAC : NEED_ONE;
      end else begin
         need = (b0[3:0] == CODEC_AVC) ? NEED_AVC : NEED_ONE;
      end
   end

   assign file_end  = (cnt_inc >= FILE_HDR_LEN);
   assign prev_end  = (cnt_inc >= PREV_LEN);
   assign tag_end   = (cnt_inc >= TAG_HDR_LEN);
   assign body_end  = (cnt_inc >= size_ff);
   assign codec_end = (cnt_inc >= {21'd0, need}) || body_end;

   // Next state
   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_inc;
      gather_in = gather_ff;
      type_in   = type_ff;
      size_in   = size_ff;
      ts_in     = ts_ff;
      stream_in = stream_ff;
      codec_in  = codec_ff;
      done      = 1'b0;
      case (phase_ff)
         PH_PREV: begin
            gather_in = {gather_ff[23:0], b};
            if (prev_end) begin
               done      = 1'b1;
               phase_in  = PH_TAG;
               cnt_in    = '0;
               gather_in = '0;
            end
         end
         PH_TAG: begin
            if (cnt_ff == 24'd0) begin
               type_in   = b;
               size_in   = '0;
               ts_in     = '0;
               stream_in = '0;
            end else if (cnt_ff <= 24'd3) begin
               size_in = {size_ff[15:0], b};
            end else if (cnt_ff <= 24'd6) begin
               ts_in = {8'd0, ts_ff[15:0], b};
            end else if (cnt_ff == 24'd7) begin
               ts_in = {b, ts_ff[23:0]};
            end else begin
               stream_in = {stream_ff[15:0], b};
            end
            if (tag_end) begin
               done     = 1'b1;
               cnt_in   = '0;
               codec_in = '0;
               if (size_ff == 24'd0) begin
                  phase_in = PH_PREV;
               end else if (type_ff == TAG_AUDIO || type_ff == TAG_VIDEO) begin
                  phase_in = PH_CODEC;
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_CODEC: begin
            codec_in = codec_upd;
            if (codec_end) begin
               if (body_end) begin
                  done     = 1'b1;
                  phase_in = PH_PREV;
                  cnt_in   = '0;
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            if (body_end) begin
               done     = 1'b1;
               phase_in = PH_PREV;
               cnt_in   = '0;
            end
         end
         default: begin
            // file header; a stray phase code parses as one too
            phase_in = PH_FILE;
            if (cnt_ff == 24'd3) begin
               codec_in[7:0] = b;
            end else if (cnt_ff == 24'd4) begin
               codec_in[15:8] = b;
            end else if (cnt_ff >= 24'd5) begin
               gather_in = {gather_ff[23:0], b};
            end
            if (file_end) begin
               done      = 1'b1;
               phase_in  = PH_PREV;
               cnt_in    = '0;
               gather_in = '0;
               codec_in  = '0;
            end
         end
      endcase
      // end of stream: start over with a fresh file
      if (item.last_byte) begin
         phase_in  = PH_FILE;
         cnt_in    = '0;
         gather_in = '0;
         type_in   = '0;
         size_in   = '0;
         ts_in     = '0;
         stream_in = '0;
         codec_in  = '0;
      end
   end

   // Outputs
   always_comb begin
      res     = '0;
      has_res = 1'b0;
      case (phase_ff)
         PH_PREV: begin
            has_res              = prev_end;
            res.data.event_res   = EV_PREV;
            res.data.word_value  = {gather_ff[23:0], b};
         end
         PH_TAG: begin
            has_res                = tag_end;
            res.data.event_res     = EV_TAG;
            res.data.word_value    = ts_ff;
            res.data.data_size     = size_ff;
            res.data.stream_ident  = {stream_ff[15:0], b};
            res.data.tag_kind      = type_ff;
         end
         PH_CODEC: begin
            has_res = codec_end;
            if (audio) begin
               res.data.event_res     = EV_AUDIO;
               res.data.codec_format  = b0[7:4];
               res.data.rate_or_frame = {2'b00, b0[3:2]};
               res.data.sample_bits   = b0[1];
               res.data.stereo        = b0[0];
            end else begin
               res.data.event_res     = EV_VIDEO;
               res.data.codec_format  = b0[3:0];
               res.data.rate_or_frame = b0[7:4];
               if (need == NEED_AVC) begin
                  res.data.composition_time = {codec_upd[15:8], codec_upd[23:16],
                                               codec_upd[31:24]};
               end
            end
            if (need != NEED_ONE) begin
               res.data.byte_value = codec_upd[15:8];
            end
         end
         PH_BODY: begin
            has_res             = 1'b1;
            res.data.event_res  = EV_PAYLOAD;
            res.data.byte_value = b;
         end
         default: begin
            has_res              = file_end;
            res.data.event_res   = EV_FILE;
            res.data.byte_value  = codec_ff[7:0];
            res.data.flags_byte  = codec_ff[15:8];
            res.data.word_value  = {gather_ff[23:0], b};
         end
      endcase
      // truncation overrides anything else for this byte
      if (item.last_byte && !done) begin
         res.data           = '0;
         res.data.event_res = EV_TRUNC;
         has_res            = 1'b1;
      end
      res.valid = has_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FILE;
         cnt_ff    <= '0;
         gather_ff <= '0;
         type_ff   <= '0;
         size_ff   <= '0;
         ts_ff     <= '0;
         stream_ff <= '0;
         codec_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         gather_ff <= gather_in;
         type_ff   <= type_in;
         size_ff   <= size_in;
         ts_ff     <= ts_in;
         stream_ff <= stream_in;
         codec_ff  <= codec_in;
      end
   end

endmodule

@@ design/flvd_out_reg.sv @@
// ----------------------------------------------------------------------------
// flvd_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module flvd_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  flvd_pkg::step_res_type res,
   output logic                   free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output flvd_pkg::rsp_type      rsp_data
);
   import flvd_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign free      = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = res.valid;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && res.valid) begin
         data_ff <= res.data;
      end
   end

endmodule

@@ dv/flvd_demux_monitor.sv @@
// ----------------------------------------------------------------------------
// flvd_demux_monitor
// Watches both channels of the FLV demuxer, parses every accepted byte with
// its own model of the demuxer and checks each result transfer, field by
// field, against the oldest pending prediction.
// ----------------------------------------------------------------------------
module flvd_demux_monitor (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  flvd_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  flvd_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import flvd_pkg::*;

   // byte positions inside the file header
   localparam logic [23:0] VERSION_AT = 24'd3;
   localparam logic [23:0] FLAGS_AT   = 24'd4;
   localparam logic [23:0] OFFSET_AT  = 24'd5;

   phase_type   parse_phase;
   logic [23:0] unit_count;
   logic [31:0] word_acc;
   logic [7:0]  tag_type;
   logic [23:0] tag_size;
   logic [31:0] tag_stamp;
   logic [23:0] tag_stream;
   logic [39:0] codec_acc;
   rsp_type     due_events[$];

   task automatic clear_parse();
      parse_phase = PH_FILE;
      unit_count  = '0;
      word_acc    = '0;
      tag_type    = '0;
      tag_size    = '0;
      tag_stamp   = '0;
      tag_stream  = '0;
      codec_acc   = '0;
   endtask

   // Advance the parser by one byte; queue the event it produces, if any.
   task automatic demux_byte(input logic [7:0] b, input logic fin);
      rsp_type    ev;
      logic       emit;
      logic       closed;
      logic       is_audio;
      logic [2:0] need;
      logic [7:0] b0;
      ev     = '0;
      emit   = 1'b0;
      closed = 1'b0;
      case (parse_phase)
         PH_PREV: begin
            word_acc = {word_acc[23:0], b};
            unit_count++;
            if (unit_count >= PREV_LEN) begin
               ev.event_res  = EV_PREV;
               ev.word_value = word_acc;
               emit          = 1'b1;
               closed        = 1'b1;
               parse_phase   = PH_TAG;
               unit_count    = '0;
               word_acc      = '0;
            end
         end
         PH_TAG: begin
            if (unit_count == 0) begin
               tag_type   = b;
               tag_size   = '0;
               tag_stamp  = '0;
               tag_stream = '0;
            end else if (unit_count <= 3) begin
               tag_size = {tag_size[15:0], b};
            end else if (unit_count <= 6) begin
               tag_stamp = {8'h00, tag_stamp[15:0], b};
            end else if (unit_count == 7) begin
               tag_stamp[31:24] = b;
            end else begin
               tag_stream = {tag_stream[15:0], b};
            end
            unit_count++;
            if (unit_count >= TAG_HDR_LEN) begin
               ev.event_res    = EV_TAG;
               ev.word_value   = tag_stamp;
               ev.data_size    = tag_size;
               ev.stream_ident = tag_stream;
               ev.tag_kind     = tag_type;
               emit            = 1'b1;
               closed          = 1'b1;
               unit_count      = '0;
               codec_acc       = '0;
               if (tag_size == 0)
                  parse_phase = PH_PREV;
               else if (tag_type == TAG_AUDIO || tag_type == TAG_VIDEO)
                  parse_phase = PH_CODEC;
               else
                  parse_phase = PH_BODY;
            end
         end
         PH_CODEC: begin
            is_audio  = (tag_type == TAG_AUDIO);
            codec_acc = codec_acc | (40'(b) << (8 * unit_count[1:0]));
            unit_count++;
            b0 = codec_acc[7:0];
            if (is_audio)
               need = (b0[7:4] == FMT_AAC) ? NEED_AAC : NEED_ONE;
            else
               need = (b0[3:0] == CODEC_AVC) ? NEED_AVC : NEED_ONE;
            // a short tag body cuts the codec header; missing bytes read zero
            if (unit_count >= need || unit_count >= tag_size) begin
               if (is_audio) begin
                  ev.event_res     = EV_AUDIO;
                  ev.codec_format  = b0[7:4];
                  ev.rate_or_frame = {2'b00, b0[3:2]};
                  ev.sample_bits   = b0[1];
                  ev.stereo        = b0[0];
               end else begin
                  ev.event_res     = EV_VIDEO;
                  ev.codec_format  = b0[3:0];
                  ev.rate_or_frame = b0[7:4];
                  if (need == NEED_AVC)
                     ev.composition_time = {codec_acc[15:8], codec_acc[23:16],
                                            codec_acc[31:24]};
               end
               if (need > NEED_ONE)
                  ev.byte_value = codec_acc[15:8];
               emit = 1'b1;
               if (unit_count >= tag_size) begin
                  closed      = 1'b1;
                  parse_phase = PH_PREV;
                  unit_count  = '0;
               end else begin
                  parse_phase = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            ev.event_res  = EV_PAYLOAD;
            ev.byte_value = b;
            emit          = 1'b1;
            unit_count++;
            if (unit_count >= tag_size) begin
               closed      = 1'b1;
               parse_phase = PH_PREV;
               unit_count  = '0;
            end
         end
         default: begin
            // file header; any stray phase value parses as one too
            if (unit_count == VERSION_AT)
               codec_acc[7:0] = b;
            else if (unit_count == FLAGS_AT)
               codec_acc[15:8] = b;
            else if (unit_count >= OFFSET_AT)
               word_acc = {word_acc[23:0], b};
            unit_count++;
            if (unit_count >= FILE_HDR_LEN) begin
               ev.event_res  = EV_FILE;
               ev.byte_value = codec_acc[7:0];
               ev.flags_byte = codec_acc[15:8];
               ev.word_value = word_acc;
               emit          = 1'b1;
               closed        = 1'b1;
               parse_phase   = PH_PREV;
               unit_count    = '0;
               word_acc      = '0;
               codec_acc     = '0;
            end
         end
      endcase
      // end of stream inside a unit replaces whatever this byte produced
      if (fin) begin
         if (!closed) begin
            ev           = '0;
            ev.event_res = EV_TRUNC;
            emit         = 1'b1;
         end
         clear_parse();
      end
      if (emit)
         due_events = {due_events, ev};
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_parse();
         due_events.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_events.size() == 0) begin
               $display("%0t: result with none expected, event expected none actual %0d",
                        $time, rsp_data.event_res);
               fail_count++;
            end else begin
               want = due_events.pop_front();
               check_field("event_res", want.event_res, rsp_data.event_res);
               check_field("byte_value", want.byte_value, rsp_data.byte_value);
               check_field("flags_byte", want.flags_byte, rsp_data.flags_byte);
               check_field("codec_format", want.codec_format, rsp_data.codec_format);
               check_field("rate_or_frame", want.rate_or_frame, rsp_data.rate_or_frame);
               check_field("sample_bits", want.sample_bits, rsp_data.sample_bits);
               check_field("stereo", want.stereo, rsp_data.stereo);
               check_field("word_value", want.word_value, rsp_data.word_value);
               check_field("data_size", want.data_size, rsp_data.data_size);
               check_field("stream_ident", want.stream_ident, rsp_data.stream_ident);
               check_field("composition_time", want.composition_time,
                           rsp_data.composition_time);
               check_field("tag_kind", want.tag_kind, rsp_data.tag_kind);
            end
         end
         if (req_valid && req_ready)
            demux_byte(req_data.data_byte, req_data.last_byte);
      end
      pending = due_events.size();
   end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Feeds the FLV demuxer directed byte streams, then random FLV files (whole,
// cut short, and raw noise) under four idle/stall phases, and reports the
// verdict from the monitor's failure count.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import flvd_pkg::*;

   localparam int          QUIET_LIMIT   = 4000;
   localparam int          RANDOM_ITEMS  = 1900;
   localparam int          SETTLE_CYCLES = 8;
   localparam logic [7:0]  TAG_SCRIPT    = 8'h12;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int idle_pct  = 0;
   int stall_pct = 0;
   int sent      = 0;
   int quiet     = 0;
   logic [7:0] file_q[$];

   always #4 clock = ~clock;

   flv_container_demuxer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   flvd_demux_monitor mon (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      rsp_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   // end the run if nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("[flv_container_demuxer] ERROR");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {b, fin};
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   // append one byte to the file under construction
   task automatic add_byte(input logic [7:0] v);
      file_q = {file_q, v};
   endtask

   task automatic add_word(input logic [31:0] v, input int n);
      for (int k = n - 1; k >= 0; k--)
         add_byte(v[8*k +: 8]);
   endtask

   task automatic send_file(input bit fin_at_end);
      foreach (file_q[i])
         send_byte(file_q[i], fin_at_end && (i == file_q.size() - 1));
   endtask

   // Build one random FLV file in file_q, possibly cut short.
   task automatic make_file();
      int          ntags;
      int          pick;
      int          size_now;
      int          cap;
      int          cut;
      int          t;
      logic [7:0]  kind;
      logic [7:0]  b;
      bit          must_cut;
      file_q   = {};
      must_cut = 1'b0;
      add_word($urandom, 3);
      add_byte(8'($urandom_range(255)));
      add_byte(8'($urandom_range(255)));
      add_word(($urandom_range(3) == 0) ? $urandom : 32'd9, 4);
      ntags = $urandom_range(4);
      for (t = 0; t < ntags && !must_cut; t++) begin
         add_word($urandom_range(1) ? $urandom : $urandom_range(60), 4);
         pick = $urandom_range(9);
         kind = (pick < 4) ? TAG_AUDIO : (pick < 8) ? TAG_VIDEO :
                (pick == 8) ? TAG_SCRIPT : 8'($urandom);
         pick = $urandom_range(99);
         if (pick < 10) begin
            size_now = 0;
         end else if (pick < 85) begin
            size_now = $urandom_range(1, 6);
         end else if (pick < 97) begin
            size_now = $urandom_range(7, 40);
         end else begin
            // huge tag: never completes, so the file must end inside it
            size_now = $urandom_range(41, 24'hFFFFFF);
            must_cut = 1'b1;
         end
         add_byte(kind);
         add_word(size_now, 3);
         add_word($urandom, 4);
         add_word(($urandom_range(3) == 0) ? $urandom : 32'd0, 3);
         cap = must_cut ? 10 : size_now;
         for (int i = 0; i < cap; i++) begin
            b = 8'($urandom);
            if (i == 0 && kind == TAG_AUDIO && $urandom_range(1))
               b[7:4] = FMT_AAC;
            if (i == 0 && kind == TAG_VIDEO && $urandom_range(1))
               b[3:0] = CODEC_AVC;
            add_byte(b);
         end
      end
      if (!must_cut && $urandom_range(1))
         add_word($urandom, 4);
      if (must_cut || $urandom_range(3) == 0) begin
         cut = $urandom_range(file_q.size() - 1);
         while (file_q.size() > cut + 1)
            void'(file_q.pop_back());
      end
   endtask

   initial begin
      int start;
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // stream ending on its first byte
      send_byte(8'h46, 1'b1);
      // header with extreme fields, zero prev size, empty video tag with the
      // extended timestamp byte set, then a stream end inside a prev size
      file_q = '{8'h46, 8'h4C, 8'h56, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'h00, 8'h00, 8'h00, 8'h00,
                 TAG_VIDEO, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'h00, 8'h00, 8'h00,
                 8'h00};
      send_file(1'b1);

      start = sent;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 58; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 58; end
            default: begin idle_pct = 36; stall_pct = 36; end
         endcase
         while (sent < start + (ph + 1) * RANDOM_ITEMS / 4) begin
            if ($urandom_range(99) < 6) begin
               // raw noise, sometimes left open so it runs into the next file
               file_q = {};
               n = $urandom_range(1, 24);
               repeat (n) add_byte(8'($urandom));
               send_file($urandom_range(1));
            end else begin
               make_file();
               send_file(1'b1);
            end
         end
      end
      req_valid <= 1'b0;
      idle_pct  = 0;
      stall_pct = 0;

      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0)
         $display("[flv_container_demuxer] OK");
      else
         $display("[flv_container_demuxer] ERROR");
      $finish;
   end

endmodule
